// ----- rtl/rc5pd_pkg.sv -----
// Package with the word types and constants of the RC-5 pulse decoder.
package rc5pd_pkg;

    localparam int unsigned MAX_PULSES = 128;
    localparam int unsigned FRAME_BITS = 14;
    localparam int unsigned MIN_PULSES = 10;

    localparam logic [15:0] NOISE_MIN_RESET = 16'd300;
    localparam logic [15:0] SHORT_MAX_RESET = 16'd1334;
    localparam logic [15:0] LONG_MAX_RESET  = 16'd2500;

    typedef enum logic [1:0] {
        CFG_NOISE_MIN = 2'd0,
        CFG_SHORT_MAX = 2'd1,
        CFG_LONG_MAX  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FEW   = 2'd1,
        ST_SHORT = 2'd2
    } frame_status_t;

    typedef enum logic {
        REQ_PULSE     = 1'b0,
        REQ_BURST_END = 1'b1
    } req_type_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] duration_us;
        logic        level_high;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [13:0] frame_code;
        logic [7:0]  command;
    } out_word_t;

endpackage

// ----- rtl/rc5_pulse_decoder.sv -----
// Top level of the RC-5 pulse decoder: input register, frame state and result register.
//
// The input channel takes one word per pulse (duration and level) or a burst-end
// word. Pulse words update the frame state and give no result. A burst-end word
// after at least one pulse gives one result word with the status, the 14-bit code
// and the command, and clears the frame state; an empty burst gives nothing.
// A word accepted at a rising edge is held in the input register and handled from
// there; its result is then registered in the result register and shown on the port.
// One word can be accepted in every cycle; the only limit is the single result
// register, which holds its word while out_stall is high. While that register is
// full and stalled, a burst-end word that gives a result waits in the input register
// and in_stall rises; pulse words keep flowing since they give no result.
// The three limit registers are written through cfg_we, cfg_index and cfg_data
// and are meant to change only while the block is idle. Writes to an index past
// the last register are ignored.
// Reset clears the frame state and both valid flags and loads the default limits
// of 300, 1334 and 2500 microseconds.
module rc5_pulse_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rc5pd_pkg::in_word_t in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output rc5pd_pkg::out_word_t out_word,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    logic [15:0] noise_min_reg;
    logic [15:0] short_max_reg;
    logic [15:0] long_max_reg;

    logic                in_valid_reg;
    rc5pd_pkg::in_word_t in_word_reg;

    logic [7:0]  pulse_count_reg, pulse_count_next;
    logic        half_pending_reg, half_pending_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [13:0] code_shift_reg, code_shift_next;

    logic                 out_valid_reg, out_valid_next;
    rc5pd_pkg::out_word_t out_word_reg, out_word_next;

    logic is_end;
    logic gives_result;
    logic out_free;
    logic advance;
    logic in_range;

    assign is_end       = in_word_reg.req_type == rc5pd_pkg::REQ_BURST_END;
    assign gives_result = in_valid_reg && is_end && (pulse_count_reg != 8'd0);
    assign out_free     = !out_valid_reg || !out_stall;
    assign advance      = !gives_result || out_free;
    assign in_stall     = in_valid_reg && !advance;
    assign in_range     = (in_word_reg.duration_us >= noise_min_reg)
                          && (in_word_reg.duration_us <= long_max_reg);

    always_comb
    begin
        pulse_count_next  = pulse_count_reg;
        half_pending_next = half_pending_reg;
        bit_count_next    = bit_count_reg;
        code_shift_next   = code_shift_reg;
        out_word_next     = out_word_reg;
        out_valid_next    = out_valid_reg && out_stall;

        if (in_valid_reg && advance)
        begin
            if (!is_end)
            begin
                if (pulse_count_reg < 8'(rc5pd_pkg::MAX_PULSES))
                begin
                    pulse_count_next = pulse_count_reg + 8'd1;
                    if ((bit_count_reg < 4'(rc5pd_pkg::FRAME_BITS)) && in_range)
                    begin
                        if (!half_pending_reg)
                        begin
                            half_pending_next = 1'b1;
                        end
                        else
                        begin
                            code_shift_next   = {code_shift_reg[12:0], in_word_reg.level_high};
                            bit_count_next    = bit_count_reg + 4'd1;
                            half_pending_next = !(in_word_reg.duration_us < short_max_reg);
                        end
                    end
                end
            end
            else if (gives_result)
            begin
                out_valid_next = 1'b1;
                if (pulse_count_reg < 8'(rc5pd_pkg::MIN_PULSES))
                begin
                    out_word_next.frame_status = rc5pd_pkg::ST_FEW;
                    out_word_next.frame_code   = '0;
                    out_word_next.command      = '0;
                end
                else if (bit_count_reg < 4'(rc5pd_pkg::FRAME_BITS))
                begin
                    out_word_next.frame_status = rc5pd_pkg::ST_SHORT;
                    out_word_next.frame_code   = '0;
                    out_word_next.command      = '0;
                end
                else
                begin
                    out_word_next.frame_status = rc5pd_pkg::ST_OK;
                    out_word_next.frame_code   = code_shift_reg;
                    out_word_next.command      = code_shift_reg[7:0];
                end
                pulse_count_next  = '0;
                half_pending_next = 1'b0;
                bit_count_next    = '0;
                code_shift_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_min_reg    <= rc5pd_pkg::NOISE_MIN_RESET;
            short_max_reg    <= rc5pd_pkg::SHORT_MAX_RESET;
            long_max_reg     <= rc5pd_pkg::LONG_MAX_RESET;
            in_valid_reg     <= 1'b0;
            pulse_count_reg  <= '0;
            half_pending_reg <= 1'b0;
            bit_count_reg    <= '0;
            code_shift_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (rc5pd_pkg::cfg_index_t'(cfg_index))
                    rc5pd_pkg::CFG_NOISE_MIN: noise_min_reg <= cfg_data;
                    rc5pd_pkg::CFG_SHORT_MAX: short_max_reg <= cfg_data;
                    rc5pd_pkg::CFG_LONG_MAX:  long_max_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            pulse_count_reg  <= pulse_count_next;
            half_pending_reg <= half_pending_next;
            bit_count_reg    <= bit_count_next;
            code_shift_reg   <= code_shift_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_word_reg <= in_word;
        end
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ----- rtl/rc5pd_checker.sv -----
// Port checker for the RC-5 pulse decoder, bound to the top level.
module rc5pd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input rc5pd_pkg::out_word_t out_word
);

    // A stalled result word stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    a_cmd_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.command == out_word.frame_code[7:0])
        else $error("command does not match the low bits of the code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.frame_status != rc5pd_pkg::ST_OK
        |-> out_word.frame_code == 14'd0)
        else $error("failed frame carries a nonzero code");

    a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.frame_status == rc5pd_pkg::ST_OK
                      || out_word.frame_status == rc5pd_pkg::ST_FEW
                      || out_word.frame_status == rc5pd_pkg::ST_SHORT)
        else $error("undefined frame status");

endmodule

bind rc5_pulse_decoder rc5pd_checker u_rc5pd_checker (.*);
